[src/hhp_pkg.sv]
// Shared types, constants and pattern lookups for the HTTP header byte parser.
// No dependencies; used by hhp_step, http_header_byte_parser and hhp_checker.

package hhp_pkg;

	// Framing characters.
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_UPPER_K = 8'h4B;
	localparam logic [7:0] CH_LOWER_K = 8'h6B;

	// Pattern matching: length of the compared words and the mismatch mark.
	localparam logic [3:0] PAT_LEN    = 4'd10;
	localparam logic [3:0] MATCH_FAIL = 4'd15;

	localparam int unsigned LIMIT_W = 10;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 10'd255;

	// Byte role codes.
	typedef enum logic [1:0] {
		ROLE_FRAME = 2'd0,
		ROLE_KEY   = 2'd1,
		ROLE_VALUE = 2'd2
	} role_t;

	// Parse phase, one-hot.
	typedef enum logic [7:0] {
		PH_START  = 8'b0000_0001,
		PH_KEY    = 8'b0000_0010,
		PH_COLON  = 8'b0000_0100,
		PH_SPACE  = 8'b0000_1000,
		PH_VALUE  = 8'b0001_0000,
		PH_CR     = 8'b0010_0000,
		PH_LF     = 8'b0100_0000,
		PH_END_CR = 8'b1000_0000
	} phase_t;

	// Parser state carried from one item to the next.
	typedef struct packed {
		phase_t              phase;
		logic [LIMIT_W-1:0]  value_count;
		logic [3:0]          key_pos;
		logic [3:0]          val_pos;
		logic                val_upper;
		logic                conn_seen;
		logic                ka_flag;
	} state_t;

	localparam state_t STATE_RESET = '{
		phase:       PH_START,
		value_count: '0,
		key_pos:     '0,
		val_pos:     '0,
		val_upper:   1'b0,
		conn_seen:   1'b0,
		ka_flag:     1'b0
	};

	// Tags produced for one item.
	typedef struct packed {
		logic [7:0] echo;
		role_t      role;
		logic       pair_done;
		logic       headers_end;
		logic       parse_error;
		logic       keep_alive;
	} result_t;

	// Character of "Connection" at a given position.
	function automatic logic [7:0] conn_char(input logic [3:0] pos);
		logic [7:0] c;
		unique case (pos)
			4'd0:    c = 8'h43; // C
			4'd1:    c = 8'h6F; // o
			4'd2:    c = 8'h6E; // n
			4'd3:    c = 8'h6E; // n
			4'd4:    c = 8'h65; // e
			4'd5:    c = 8'h63; // c
			4'd6:    c = 8'h74; // t
			4'd7:    c = 8'h69; // i
			4'd8:    c = 8'h6F; // o
			4'd9:    c = 8'h6E; // n
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// Character of "keep-alive" or "Keep-Alive" at a given position.
	function automatic logic [7:0] ka_char(input logic [3:0] pos, input logic upper);
		logic [7:0] c;
		unique case (pos)
			4'd0:    c = upper ? 8'h4B : 8'h6B; // K / k
			4'd1:    c = 8'h65;                 // e
			4'd2:    c = 8'h65;                 // e
			4'd3:    c = 8'h70;                 // p
			4'd4:    c = 8'h2D;                 // -
			4'd5:    c = upper ? 8'h41 : 8'h61; // A / a
			4'd6:    c = 8'h6C;                 // l
			4'd7:    c = 8'h69;                 // i
			4'd8:    c = 8'h76;                 // v
			4'd9:    c = 8'h65;                 // e
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

[src/hhp_step.sv]
// Next-state and tag logic of the HTTP header byte parser for one byte.
// Purely combinational; depends on hhp_pkg.

module hhp_step (
	input  hhp_pkg::state_t                 state_q,
	input  logic [7:0]                      data,
	input  logic [hhp_pkg::LIMIT_W-1:0]     limit,
	output hhp_pkg::state_t                 state_d,
	output hhp_pkg::result_t                res
);

	logic                         is_crlf;
	logic                         err;
	logic [hhp_pkg::LIMIT_W:0]    count_inc;
	logic [3:0]                   key_first;
	hhp_pkg::state_t              nxt;

	assign is_crlf   = (data == hhp_pkg::CH_CR) || (data == hhp_pkg::CH_LF);
	assign count_inc = {1'b0, state_q.value_count} + 1'b1;
	// Match progress for the first byte of a new key.
	assign key_first = (data == hhp_pkg::conn_char(4'd0)) ? 4'd1 : hhp_pkg::MATCH_FAIL;

	// Phase decode for one byte.
	always_comb begin
		nxt = state_q;
		err = 1'b0;
		res = '{echo: data, role: hhp_pkg::ROLE_FRAME, pair_done: 1'b0,
			headers_end: 1'b0, parse_error: 1'b0, keep_alive: 1'b0};
		unique case (state_q.phase)
			hhp_pkg::PH_KEY: begin
				if (data == hhp_pkg::CH_COLON) begin
					nxt.conn_seen = (state_q.key_pos == hhp_pkg::PAT_LEN);
					nxt.phase     = hhp_pkg::PH_COLON;
				end else if (is_crlf) begin
					err = 1'b1;
				end else begin
					if (state_q.key_pos < hhp_pkg::PAT_LEN &&
						data == hhp_pkg::conn_char(state_q.key_pos)) begin
						nxt.key_pos = state_q.key_pos + 4'd1;
					end else begin
						nxt.key_pos = hhp_pkg::MATCH_FAIL;
					end
					res.role = hhp_pkg::ROLE_KEY;
				end
			end
			hhp_pkg::PH_COLON: begin
				if (data == hhp_pkg::CH_SPACE) begin
					nxt.phase = hhp_pkg::PH_SPACE;
				end else begin
					err = 1'b1;
				end
			end
			hhp_pkg::PH_SPACE: begin
				// The byte after colon-space always opens the value.
				nxt.value_count = '0;
				nxt.val_upper   = (data == hhp_pkg::CH_UPPER_K);
				nxt.val_pos     = (data == hhp_pkg::CH_UPPER_K || data == hhp_pkg::CH_LOWER_K)
					? 4'd1 : hhp_pkg::MATCH_FAIL;
				nxt.phase       = hhp_pkg::PH_VALUE;
				res.role        = hhp_pkg::ROLE_VALUE;
			end
			hhp_pkg::PH_VALUE: begin
				if (data == hhp_pkg::CH_CR) begin
					nxt.phase = hhp_pkg::PH_CR;
				end else if (count_inc > {1'b0, limit}) begin
					err = 1'b1;
				end else begin
					nxt.value_count = count_inc[hhp_pkg::LIMIT_W-1:0];
					if (state_q.val_pos < hhp_pkg::PAT_LEN &&
						data == hhp_pkg::ka_char(state_q.val_pos, state_q.val_upper)) begin
						nxt.val_pos = state_q.val_pos + 4'd1;
					end else begin
						nxt.val_pos = hhp_pkg::MATCH_FAIL;
					end
					res.role = hhp_pkg::ROLE_VALUE;
				end
			end
			hhp_pkg::PH_CR: begin
				if (data == hhp_pkg::CH_LF) begin
					if (state_q.conn_seen) begin
						nxt.ka_flag = (state_q.val_pos == hhp_pkg::PAT_LEN);
					end
					nxt.conn_seen = 1'b0;
					nxt.phase     = hhp_pkg::PH_LF;
					res.pair_done = 1'b1;
				end else begin
					err = 1'b1;
				end
			end
			hhp_pkg::PH_LF: begin
				if (data == hhp_pkg::CH_CR) begin
					nxt.phase = hhp_pkg::PH_END_CR;
				end else begin
					nxt.key_pos = key_first;
					nxt.phase   = hhp_pkg::PH_KEY;
					res.role    = hhp_pkg::ROLE_KEY;
				end
			end
			hhp_pkg::PH_END_CR: begin
				if (data == hhp_pkg::CH_LF) begin
					res.headers_end = 1'b1;
					res.keep_alive  = state_q.ka_flag;
					nxt = hhp_pkg::STATE_RESET;
				end else begin
					err = 1'b1;
				end
			end
			default: begin
				// Start phase; unused codes behave the same way.
				if (!is_crlf) begin
					nxt.key_pos = key_first;
					nxt.phase   = hhp_pkg::PH_KEY;
					res.role    = hhp_pkg::ROLE_KEY;
				end else begin
					nxt.phase = hhp_pkg::PH_START;
				end
			end
		endcase

		// A syntax error raises parse_error, clears the role and the other flags, and restarts the parse.
		if (err) begin
			nxt             = hhp_pkg::STATE_RESET;
			res.role        = hhp_pkg::ROLE_FRAME;
			res.pair_done   = 1'b0;
			res.headers_end = 1'b0;
			res.keep_alive  = 1'b0;
			res.parse_error = 1'b1;
		end
	end

	assign state_d = nxt;

endmodule

[src/http_header_byte_parser.sv]
// HTTP header byte parser: one byte per clock in, one tagged byte per clock out while the output is not stalled.
// Depends on hhp_pkg and hhp_step.

// The parser accepts one header byte per clock and returns one tagged result
// per byte, in order, via the input register and the result register. Sustained
// throughput is one byte per clock while out_ready does not stall the output;
// it is set by the parse state update in hhp_step, which sits between the two.
// value_length_limit resets to 255. The user must write it through cfg_wr_en /
// cfg_wr_data only while no bytes are in flight; the block does not enforce it.

module http_header_byte_parser (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [hhp_pkg::LIMIT_W-1:0]   cfg_wr_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [7:0]                    data_byte,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [7:0]                    byte_echo,
	output logic [1:0]                    byte_role,
	output logic                          pair_done,
	output logic                          headers_end,
	output logic                          parse_error,
	output logic                          keep_alive
);

	logic                         valid_s1;
	logic [7:0]                   byte_s1;
	logic                         valid_s2;
	hhp_pkg::result_t             res_s2;
	hhp_pkg::result_t             res_d;
	hhp_pkg::state_t              state_q;
	hhp_pkg::state_t              state_d;
	logic [hhp_pkg::LIMIT_W-1:0]  limit_q;
	logic                         advance;

	// Stage 1 moves into the result register when that register is free or drains.
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= hhp_pkg::LIMIT_RESET;
		end else if (cfg_wr_en) begin
			limit_q <= cfg_wr_data;
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= data_byte;
		end
	end

	hhp_step u_step (
		.state_q (state_q),
		.data    (byte_s1),
		.limit   (limit_q),
		.state_d (state_d),
		.res     (res_d)
	);

	// Parse state advances once per item as it enters the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hhp_pkg::STATE_RESET;
		end else if (advance) begin
			state_q <= state_d;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_d;
		end
	end

	assign out_valid   = valid_s2;
	assign byte_echo   = res_s2.echo;
	assign byte_role   = res_s2.role;
	assign pair_done   = res_s2.pair_done;
	assign headers_end = res_s2.headers_end;
	assign parse_error = res_s2.parse_error;
	assign keep_alive  = res_s2.keep_alive;

endmodule

[src/hhp_checker.sv]
// Port-level checks for the HTTP header byte parser, bound to the top level.
// Depends on hhp_pkg and http_header_byte_parser.

module hhp_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [7:0]                    byte_echo,
	input logic [1:0]                    byte_role,
	input logic                          pair_done,
	input logic                          headers_end,
	input logic                          parse_error,
	input logic                          keep_alive
);

	// An offered item stays offered until it is taken.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_ready) |=> in_valid)
		else $error("in_valid dropped before the item was taken");

	// An error item carries no other tag.
	a_error_alone: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && parse_error) |->
			(byte_role == hhp_pkg::ROLE_FRAME && !pair_done && !headers_end && !keep_alive))
		else $error("parse_error item carries other tags");

	// Keep-alive is only reported on the closing line.
	a_ka_on_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && keep_alive) |-> headers_end)
		else $error("keep_alive without headers_end");

	// Pair and header-end marks only fall on an LF and never together.
	a_marks_on_lf: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (pair_done || headers_end)) |->
			(byte_echo == hhp_pkg::CH_LF && !(pair_done && headers_end)))
		else $error("pair_done or headers_end on a wrong byte");

	// A stalled item is held unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=>
			(out_valid && $stable(byte_echo) && $stable(byte_role) && $stable(pair_done)
			&& $stable(headers_end) && $stable(parse_error) && $stable(keep_alive)))
		else $error("stalled item changed");

endmodule

bind http_header_byte_parser hhp_checker u_hhp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.byte_echo   (byte_echo),
	.byte_role   (byte_role),
	.pair_done   (pair_done),
	.headers_end (headers_end),
	.parse_error (parse_error),
	.keep_alive  (keep_alive)
);
